>>> rtl/sust_pkg.sv
// Package for the sorted unique set table: item types, kind codes,
// controller states and the default capacity. No dependencies.
`timescale 1ns / 1ps

package sust_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int COUNT_W      = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic               inserted;
        logic               dropped_full;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    // Per-cell status handed from a cell to the controller and its right neighbor.
    typedef struct packed {
        logic eq;
        logic slot;
    } t_cell_flags;

endpackage

>>> rtl/sust_cell.sv
// One cell of the sorted chain: holds a single entry, compares it against the
// broadcast key and shifts or loads on insert. Depends on sust_pkg.
`timescale 1ns / 1ps

module sust_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmp_en,
    input  logic                 i_shift_en,
    input  logic                 i_occ,
    input  logic                 i_at_end,
    input  logic signed [31:0]   i_key,
    input  logic                 i_left_slot,
    input  logic signed [31:0]   i_left_entry,
    output logic signed [31:0]   o_entry,
    output sust_pkg::t_cell_flags o_flags
);

    logic signed [31:0]    r_entry;
    sust_pkg::t_cell_flags r_flags;
    sust_pkg::t_cell_flags n_flags;

    // A cell is a slot when the key sorts before its entry, or when it is
    // the first free cell. Every slot right of the first one takes its left
    // neighbor's entry, and the first slot takes the key.
    always_comb begin
        n_flags.eq   = i_occ && (r_entry == i_key);
        n_flags.slot = (i_occ && (i_key < r_entry)) || i_at_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_cmp_en) begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift_en) begin
            if (i_left_slot) begin
                r_entry <= i_left_entry;
            end else if (r_flags.slot) begin
                r_entry <= i_key;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

>>> rtl/sorted_unique_set_table_top.sv
// Sorted unique set table: a chain of compare-and-shift cells with a small
// controller and an output register. Depends on sust_pkg and sust_cell.
//
// The table keeps up to CAPACITY distinct signed 32-bit values in ascending
// order, one per cell. An item passes an accept step, a compare step in which
// every cell compares its entry with the value and registers the outcome, and
// an update step in which the present flags are combined and an insert shifts
// the larger entries one cell up. The next item is accepted while a finished
// result still waits in the output register; the update step waits only while
// that register is full and the output is stalled. Inserts of a value already
// present change nothing, and a new value inserted into a full table is dropped
// and flagged. The count field carries the low five bits of the element count.
`timescale 1ns / 1ps

module sorted_unique_set_table_top #(
    parameter int CAPACITY = sust_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sust_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sust_pkg::t_out_item o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    sust_pkg::t_state    r_state;
    sust_pkg::t_state    n_state;
    sust_pkg::t_in_item  r_item;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    sust_pkg::t_out_item r_out;
    sust_pkg::t_out_item n_out;

    logic signed [31:0]    w_entry [CAPACITY];
    sust_pkg::t_cell_flags w_flags [CAPACITY];
    logic [CAPACITY-1:0]   w_eq;

    logic in_acc;
    logic upd_go;
    logic found;
    logic full;
    logic do_insert;

    assign o_in_stall = (r_state != sust_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign upd_go     = (r_state == sust_pkg::S_UPD) && !(r_out_valid && i_out_stall);

    assign found     = |w_eq;
    assign full      = (r_count == CW'(CAPACITY));
    assign do_insert = upd_go && (r_item.kind == sust_pkg::KIND_INSERT) && !found && !full;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(g);
            logic               left_slot;
            logic signed [31:0] left_entry;

            if (g == 0) begin : g_first
                assign left_slot  = 1'b0;
                assign left_entry = r_item.value;
            end else begin : g_rest
                assign left_slot  = w_flags[g-1].slot;
                assign left_entry = w_entry[g-1];
            end

            sust_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmp_en     (r_state == sust_pkg::S_CMP),
                .i_shift_en   (do_insert),
                .i_occ        (IDX < r_count),
                .i_at_end     (IDX == r_count),
                .i_key        (r_item.value),
                .i_left_slot  (left_slot),
                .i_left_entry (left_entry),
                .o_entry      (w_entry[g]),
                .o_flags      (w_flags[g])
            );

            assign w_eq[g] = w_flags[g].eq;
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            sust_pkg::S_IDLE: if (in_acc) n_state = sust_pkg::S_CMP;
            sust_pkg::S_CMP:  n_state = sust_pkg::S_UPD;
            sust_pkg::S_UPD:  if (upd_go) n_state = sust_pkg::S_IDLE;
            default:          n_state = sust_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count            = do_insert ? r_count + CW'(1) : r_count;
        n_out.found        = found;
        n_out.inserted     = do_insert;
        n_out.dropped_full = (r_item.kind == sust_pkg::KIND_INSERT) && !found && full;
        n_out.count        = sust_pkg::COUNT_W'(n_count);
        n_out.is_empty     = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sust_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (upd_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in;
        end
        if (upd_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sust_pkg::S_UPD) |=> $stable(r_count))
        else $error("element count changed outside the update cycle");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> !(o_out.inserted && (o_out.found || o_out.dropped_full)))
        else $error("insert reported together with found or dropped");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> o_out_valid && (r_state == sust_pkg::S_IDLE))
        else $error("update cycle did not deliver a result");

endmodule

>>> sim/sorted_unique_set_table_top_test.sv
// Self-checking testbench for sorted_unique_set_table_top: drives insert and query items,
// predicts every result from a sorted member list and compares it field by field.
// Depends on sust_pkg and the RTL of the table.
`timescale 1ns / 1ps

module sorted_unique_set_table_top_test;

    localparam int TABLE_DEPTH  = sust_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1225;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    sust_pkg::t_in_item  i_in;
    logic                o_out_valid;
    logic                i_out_stall;
    sust_pkg::t_out_item o_out;

    // Items waiting to be driven, and the values the generator expects to be stored.
    sust_pkg::t_in_item  item_backlog[$];
    logic signed [31:0]  planned_members[$];
    // Predictor state: the stored values in ascending signed order.
    logic signed [31:0]  member_list[$];
    sust_pkg::t_out_item predicted_status[$];

    int   total_items;
    int   items_sent;
    int   items_accepted;
    int   fail_count;
    int   quiet_cycles;
    logic in_taken;
    logic out_taken;

    sorted_unique_set_table_top #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic is_planned(logic signed [31:0] value);
        foreach (planned_members[k]) begin
            if (planned_members[k] == value) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic plan_item(logic kind, logic signed [31:0] value);
        sust_pkg::t_in_item item;
        item.kind  = kind;
        item.value = value;
        item_backlog.push_back(item);
        if (kind == sust_pkg::KIND_INSERT && planned_members.size() < TABLE_DEPTH &&
            !is_planned(value))
            planned_members.push_back(value);
    endtask

    // Values are mostly stored members, their neighbors or their twins with the sign bit flipped,
    // so that lookups hit and near-miss the compare chain.
    function automatic logic signed [31:0] pick_value();
        int                 sel;
        logic signed [31:0] base;
        sel = $urandom_range(99);
        if (sel >= 90) begin
            case ($urandom_range(4))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sd0;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        if (sel >= 60 || planned_members.size() == 0) return $urandom;
        base = planned_members[$urandom_range(planned_members.size() - 1)];
        if (sel < 30) return base;
        if (sel < 50) return sel[0] ? base + 32'sd1 : base - 32'sd1;
        return base ^ 32'sh8000_0000;
    endfunction

    function automatic sust_pkg::t_out_item predict_set_status(sust_pkg::t_in_item item);
        sust_pkg::t_out_item status;
        logic signed [31:0]  value;
        logic                present;
        int                  pos;
        value   = item.value;
        present = 1'b0;
        pos     = member_list.size();
        status  = '0;
        for (int k = 0; k < member_list.size(); k++) begin
            if (member_list[k] == value) begin
                present = 1'b1;
                pos     = k;
                break;
            end
            if (value < member_list[k]) begin
                pos = k;
                break;
            end
        end
        status.found = present;
        if (item.kind == sust_pkg::KIND_INSERT && !present) begin
            if (member_list.size() >= TABLE_DEPTH) begin
                status.dropped_full = 1'b1;
            end else begin
                member_list.insert(pos, value);
                status.inserted = 1'b1;
            end
        end
        status.count    = sust_pkg::COUNT_W'(member_list.size());
        status.is_empty = (member_list.size() == 0);
        return status;
    endfunction

    task automatic compare_field(string name, logic [sust_pkg::COUNT_W-1:0] want,
                                 logic [sust_pkg::COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge i_clk) begin : driver
        int phase;
        int send_idle_pct;
        int out_stall_pct;
        phase         = (total_items == 0) ? 2 : (items_sent * 3) / total_items;
        send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 47 : 0;
        out_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 10 : 0;
        if (i_rst_n) begin
            // A pending item is held until it has been taken.
            if (!i_in_valid || in_taken) begin
                if (item_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in       <= item_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    items_sent++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        sust_pkg::t_out_item want;
        in_taken  = i_rst_n && i_in_valid && !o_in_stall;
        out_taken = i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        if (out_taken) begin
            if (predicted_status.size() == 0) begin
                $error("result with no item outstanding: %p", o_out);
                fail_count++;
            end else begin
                want = predicted_status.pop_front();
                compare_field("found", sust_pkg::COUNT_W'(want.found),
                              sust_pkg::COUNT_W'(o_out.found));
                compare_field("inserted", sust_pkg::COUNT_W'(want.inserted),
                              sust_pkg::COUNT_W'(o_out.inserted));
                compare_field("dropped_full", sust_pkg::COUNT_W'(want.dropped_full),
                              sust_pkg::COUNT_W'(o_out.dropped_full));
                compare_field("count", want.count, o_out.count);
                compare_field("is_empty", sust_pkg::COUNT_W'(want.is_empty),
                              sust_pkg::COUNT_W'(o_out.is_empty));
            end
        end
        if (in_taken) begin
            predicted_status.push_back(predict_set_status(i_in));
            items_accepted++;
        end
        quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_out_stall    = 1'b0;
        i_in           = '0;
        total_items    = 0;
        items_sent     = 0;
        items_accepted = 0;
        fail_count     = 0;
        quiet_cycles   = 0;
        in_taken       = 1'b0;
        out_taken      = 1'b0;

        // Directed part: empty table, extremes at both ends, a duplicate insert,
        // hits and misses, then a fill to capacity and inserts into the full table.
        plan_item(sust_pkg::KIND_QUERY, 32'sd0);
        plan_item(sust_pkg::KIND_INSERT, 32'sd0);
        plan_item(sust_pkg::KIND_INSERT, 32'sh8000_0000);
        plan_item(sust_pkg::KIND_INSERT, 32'sh7fff_ffff);
        plan_item(sust_pkg::KIND_INSERT, 32'sd0);
        plan_item(sust_pkg::KIND_INSERT, -32'sd1);
        plan_item(sust_pkg::KIND_INSERT, 32'sd1);
        plan_item(sust_pkg::KIND_QUERY, 32'sh7fff_ffff);
        plan_item(sust_pkg::KIND_QUERY, 32'sh8000_0000);
        plan_item(sust_pkg::KIND_QUERY, 32'sd2);
        plan_item(sust_pkg::KIND_QUERY, 32'sh8000_0001);
        while (planned_members.size() < TABLE_DEPTH)
            plan_item(sust_pkg::KIND_INSERT, $urandom);
        plan_item(sust_pkg::KIND_INSERT, 32'sd2);
        plan_item(sust_pkg::KIND_INSERT, 32'sh8000_0000);
        plan_item(sust_pkg::KIND_QUERY, 32'sd2);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            plan_item(1'($urandom_range(1)), pick_value());
        total_items = item_backlog.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_accepted < total_items || predicted_status.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/sust_pkg.sv
rtl/sust_cell.sv
rtl/sorted_unique_set_table_top.sv
sim/sorted_unique_set_table_top_test.sv
